FILE: rtl/oal_pkg.sv
// package: sizes, operation and status codes, and the cell command word for the ordered list
`default_nettype none
package oal_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int FUNC_W = 3;
   localparam int POS_W  = 4;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 3;
   localparam int FIDX_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_BACK  = 3'd0,
      FUNC_PUSH_FRONT = 3'd1,
      FUNC_POP_BACK   = 3'd2,
      FUNC_POP_FRONT  = 3'd3,
      FUNC_INSERT     = 3'd4,
      FUNC_ERASE      = 3'd5,
      FUNC_FIND       = 3'd6
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic                    shift_up;
      logic                    shift_down;
      logic [IDX_W-1:0]        at;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/oal_req_if.sv
// interface: request channel carrying one operation word
`default_nettype none
interface oal_req_if;
   logic                                valid;
   logic                                ready;
   logic [oal_pkg::FUNC_W-1:0]          func;
   logic [oal_pkg::POS_W-1:0]           position;
   logic signed [oal_pkg::VAL_W-1:0]    value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/oal_rsp_if.sv
// interface: response channel carrying one result word
`default_nettype none
interface oal_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oal_pkg::STAT_W-1:0]    status;
   logic [oal_pkg::FIDX_W-1:0]    found_index;
   logic [oal_pkg::CNT_W-1:0]     count;

   modport source (output valid, output status, output found_index, output count, input ready);
   modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface
`default_nettype wire

FILE: rtl/ordered_array_list_core.sv
// top level: ordered list of signed words built as a row of shifting cells
// Holds up to CAPACITY signed 32-bit entries in a row of cells that shift and compare
// in parallel, so every operation (push, pop, insert, erase, find) acts on all cells together:
// a request word is taken whenever the result register is empty or being drained,
// and its result word is registered and appears in the next cycle, so one word per cycle
// is sustained while results are drained as they come. Entry storage is not cleared at
// reset; only the entry count is, and entries above the count are never reported.
`default_nettype none
module ordered_array_list_core (
   input  wire logic clock,
   input  wire logic reset,
   oal_req_if.sink   req,
   oal_rsp_if.source rsp
);

   localparam int N = oal_pkg::CAPACITY;

   logic accept;
   logic [oal_pkg::CNT_W-1:0]  count_ff;
   logic [oal_pkg::CNT_W-1:0]  count_in;
   oal_pkg::cell_cmd_type      cmd;
   oal_pkg::status_type        dec_status;
   oal_pkg::status_type        status_in;
   logic [oal_pkg::FIDX_W-1:0] found_in;

   logic signed [oal_pkg::VAL_W-1:0] entry [N];
   logic [N-1:0] match;

   logic                       rsp_valid_ff;
   logic [oal_pkg::STAT_W-1:0] rsp_status_ff;
   logic [oal_pkg::FIDX_W-1:0] rsp_found_ff;
   logic [oal_pkg::CNT_W-1:0]  rsp_count_ff;

   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   oal_decode u_decode (
      .fire     (accept),
      .func     (req.func),
      .position (req.position),
      .value    (req.value),
      .count    (count_ff),
      .cmd      (cmd),
      .status   (dec_status),
      .count_in (count_in)
   );

   for (genvar g = 0; g < N; g++) begin : g_cell
      oal_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (oal_pkg::IDX_W'(g)),
         .left_entry  ((g == 0) ? cmd.value : entry[(g == 0) ? 0 : g - 1]),
         .right_entry ((g == N - 1) ? entry[g] : entry[(g == N - 1) ? g : g + 1]),
         .entry       (entry[g]),
         .match       (match[g])
      );
   end

   // first match wins
   always_comb begin
      status_in = dec_status;
      found_in  = '0;
      if (oal_pkg::func_type'(req.func) == oal_pkg::FUNC_FIND) begin
         for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) begin
               status_in = oal_pkg::STAT_OK;
               found_in  = oal_pkg::FIDX_W'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.found_index = rsp_found_ff;
   assign rsp.count       = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= oal_pkg::CNT_W'(oal_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_count_ff == count_ff)
      else $error("result word missing or count mismatch");

   a_find_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && oal_pkg::func_type'(req.func) == oal_pkg::FUNC_FIND |=> $stable(count_ff))
      else $error("find changed the entry count");

   a_no_shift_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> !cmd.shift_up && !cmd.shift_down)
      else $error("cells shifted without an accepted word");

endmodule
`default_nettype wire

FILE: rtl/oal_decode.sv
// operation decoder: bounds checks, next count and the command word broadcast to all cells
`default_nettype none
module oal_decode (
   input  wire logic                             fire,
   input  wire logic [oal_pkg::FUNC_W-1:0]       func,
   input  wire logic [oal_pkg::POS_W-1:0]        position,
   input  wire logic signed [oal_pkg::VAL_W-1:0] value,
   input  wire logic [oal_pkg::CNT_W-1:0]        count,
   output oal_pkg::cell_cmd_type                 cmd,
   output oal_pkg::status_type                   status,
   output logic [oal_pkg::CNT_W-1:0]             count_in
);

   logic full;
   logic empty;
   logic up;
   logic down;
   logic [oal_pkg::IDX_W-1:0] at;

   assign full  = count >= oal_pkg::CNT_W'(oal_pkg::CAPACITY);
   assign empty = count == '0;

   always_comb begin
      status   = oal_pkg::STAT_OK;
      count_in = count;
      up       = 1'b0;
      down     = 1'b0;
      at       = '0;
      unique case (oal_pkg::func_type'(func))
         oal_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               status = oal_pkg::STAT_FULL;
            end else begin
               up       = 1'b1;
               at       = oal_pkg::IDX_W'(count);
               count_in = count + 1'b1;
            end
         end
         oal_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               status = oal_pkg::STAT_FULL;
            end else begin
               up       = 1'b1;
               count_in = count + 1'b1;
            end
         end
         oal_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               status = oal_pkg::STAT_EMPTY;
            end else begin
               count_in = count - 1'b1;
            end
         end
         oal_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               status = oal_pkg::STAT_EMPTY;
            end else begin
               down     = 1'b1;
               count_in = count - 1'b1;
            end
         end
         oal_pkg::FUNC_INSERT: begin
            priority if (full) begin
               status = oal_pkg::STAT_FULL;
            end else if (int'(position) > int'(count)) begin
               status = oal_pkg::STAT_BAD_POS;
            end else begin
               up       = 1'b1;
               at       = oal_pkg::IDX_W'(position);
               count_in = count + 1'b1;
            end
         end
         oal_pkg::FUNC_ERASE: begin
            priority if (empty) begin
               status = oal_pkg::STAT_EMPTY;
            end else if (int'(position) >= int'(count)) begin
               status = oal_pkg::STAT_BAD_POS;
            end else begin
               down     = 1'b1;
               at       = oal_pkg::IDX_W'(position);
               count_in = count - 1'b1;
            end
         end
         oal_pkg::FUNC_FIND: begin
            status = oal_pkg::STAT_NOT_FOUND;
         end
         default: begin
            status = oal_pkg::STAT_OK;
         end
      endcase
   end

   assign cmd.shift_up   = fire && up;
   assign cmd.shift_down = fire && down;
   assign cmd.at         = at;
   assign cmd.value      = value;
   assign cmd.count      = count;

endmodule
`default_nettype wire

FILE: rtl/oal_cell.sv
// list cell: one entry, shifted from either neighbor, and its key compare
`default_nettype none
module oal_cell (
   input  wire logic                             clock,
   input  wire oal_pkg::cell_cmd_type            cmd,
   input  wire logic [oal_pkg::IDX_W-1:0]        cell_index,
   input  wire logic signed [oal_pkg::VAL_W-1:0] left_entry,
   input  wire logic signed [oal_pkg::VAL_W-1:0] right_entry,
   output logic signed [oal_pkg::VAL_W-1:0]      entry,
   output logic                                  match
);

   logic signed [oal_pkg::VAL_W-1:0] entry_ff;
   logic signed [oal_pkg::VAL_W-1:0] entry_in;

   always_comb begin
      priority if (cmd.shift_up && cell_index > cmd.at) begin
         entry_in = left_entry;
      end else if (cmd.shift_up && cell_index == cmd.at) begin
         entry_in = cmd.value;
      end else if (cmd.shift_down && cell_index >= cmd.at) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == cmd.value) && (oal_pkg::CNT_W'(cell_index) < cmd.count);

endmodule
`default_nettype wire
